FILE: hdl/sit_pkg.sv
// -----------------------------------------------------------------------------
// Segment intersection test package
// Shared types and coordinate slot numbers for the segment crossing pipeline.
// -----------------------------------------------------------------------------
`default_nettype none

package sit_pkg;

   // Control that travels with each pipeline beat.
   typedef struct packed {
      logic valid;
      logic neg;
   } ctl_type;

   // Slot numbers of the eight coordinates in the packed coordinate word.
   localparam int unsigned P1X = 0;
   localparam int unsigned P1Y = 1;
   localparam int unsigned Q1X = 2;
   localparam int unsigned Q1Y = 3;
   localparam int unsigned P2X = 4;
   localparam int unsigned P2Y = 5;
   localparam int unsigned Q2X = 6;
   localparam int unsigned Q2Y = 7;
   localparam int unsigned NUM_COORDS = 8;

endpackage

`default_nettype wire

FILE: hdl/sit_div.sv
// -----------------------------------------------------------------------------
// Pipelined fixed-point divider
// Restoring division, one quotient bit per stage, truncated toward zero and
// saturated to a signed OW-bit result. A side tag travels with each beat.
// -----------------------------------------------------------------------------
`default_nettype none

module sit_div #(
   parameter int NW = 33,
   parameter int FB = 16,
   parameter int OW = 32,
   parameter int TW = 1
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic [NW-1:0]        in_num,
   input  wire logic [NW-1:0]        in_den,
   input  wire logic [TW-1:0]        in_tag,
   output logic                      out_valid,
   output logic [OW-1:0]             out_quo,
   output logic [TW-1:0]             out_tag
);

   localparam int QB = NW + FB;
   localparam logic [QB-1:0] POS_Q = {{(QB-OW+1){1'b0}}, {(OW-1){1'b1}}};
   localparam logic [QB-1:0] MIN_Q = POS_Q + 1'b1;

   sit_pkg::ctl_type ctl_ff [0:QB];
   logic [NW-1:0]    rem_ff [0:QB];
   logic [QB-1:0]    quo_ff [0:QB];
   logic [NW-1:0]    dvs_ff [0:QB];
   logic [TW-1:0]    tag_ff [0:QB];

   logic [NW-1:0]    un_in;
   logic [NW-1:0]    ud_in;
   logic [OW-1:0]    quo_in;
   logic             vld_ff;
   logic [OW-1:0]    quo_out_ff;
   logic [TW-1:0]    tag_out_ff;

   // Magnitudes of the operands; the sign of the result is kept apart.
   assign un_in = in_num[NW-1] ? (~in_num + 1'b1) : in_num;
   assign ud_in = in_den[NW-1] ? (~in_den + 1'b1) : in_den;

   // Entry stage: the dividend is the numerator magnitude shifted by FB.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0].valid <= 1'b0;
      end else begin
         ctl_ff[0].valid <= in_valid;
      end
      ctl_ff[0].neg <= in_num[NW-1] ^ in_den[NW-1];
      rem_ff[0]     <= '0;
      quo_ff[0]     <= QB'(un_in) << FB;
      dvs_ff[0]     <= ud_in;
      tag_ff[0]     <= in_tag;
   end

   // One restoring step per stage.
   for (genvar g = 0; g < QB; g++) begin : g_step
      logic [NW:0] trial;
      logic [NW:0] diff;
      logic        ge;

      assign trial = {rem_ff[g], quo_ff[g][QB-1]};
      assign diff  = trial - {1'b0, dvs_ff[g]};
      assign ge    = trial >= {1'b0, dvs_ff[g]};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[g+1].valid <= 1'b0;
         end else begin
            ctl_ff[g+1].valid <= ctl_ff[g].valid;
         end
         ctl_ff[g+1].neg <= ctl_ff[g].neg;
         rem_ff[g+1]     <= ge ? diff[NW-1:0] : trial[NW-1:0];
         quo_ff[g+1]     <= {quo_ff[g][QB-2:0], ge};
         dvs_ff[g+1]     <= dvs_ff[g];
         tag_ff[g+1]     <= tag_ff[g];
      end
   end

   // Apply the sign and saturate to the output range.
   always_comb begin
      if (!ctl_ff[QB].neg) begin
         quo_in = (quo_ff[QB] > POS_Q) ? POS_Q[OW-1:0] : quo_ff[QB][OW-1:0];
      end else begin
         quo_in = (quo_ff[QB] > MIN_Q) ? MIN_Q[OW-1:0] : (~quo_ff[QB][OW-1:0] + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= ctl_ff[QB].valid;
      end
      quo_out_ff <= quo_in;
      tag_out_ff <= tag_ff[QB];
   end

   assign out_valid = vld_ff;
   assign out_quo   = quo_out_ff;
   assign out_tag   = tag_out_ff;

endmodule

`default_nettype wire

FILE: hdl/segment_intersection_test_top.sv
// -----------------------------------------------------------------------------
// Segment intersection test
// Decides whether two fixed-point line segments cross, fully pipelined.
// -----------------------------------------------------------------------------
// A new segment pair is taken on every clock cycle (busy stays low) and its
// answer appears on rsp_crosses with a one-cycle rsp_valid strobe, in order;
// the receiver cannot stall and must take each beat in the cycle it is shown.
// Most of the pipeline depth lies in two bit-per-stage divider passes in
// series: the two slope dividers work side by side, then one forms the
// crossing x.
`default_nettype none

module segment_intersection_test_top #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [COORD_BITS-1:0] req_a_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_a_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_a_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_a_end_y,
   input  wire logic signed [COORD_BITS-1:0] req_b_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_b_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_b_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_b_end_y,
   output logic                              rsp_valid,
   output logic                              rsp_crosses
);

   localparam int W  = COORD_BITS;
   localparam int F  = FRAC_BITS;
   localparam int NC = sit_pkg::NUM_COORDS;
   localparam int TA = NC * W + 2;
   localparam int TC = NC * W + 4 * W + 3;
   localparam logic [2*W-1:0] POS_P = {{(W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic [2*W-1:0] MIN_P = POS_P + 1'b1;
   localparam logic [W-1:0]   POS_W = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0]   MIN_W = {1'b1, {(W-1){1'b0}}};

   // Truncate a product magnitude by F bits, apply its sign and saturate.
   function automatic logic [W-1:0] sat_mul(input logic [2*W-1:0] p, input logic n);
      logic [2*W-1:0] sh;
      logic [W-1:0]   res;
      sh = p >> F;
      if (!n) begin
         res = (sh > POS_P) ? POS_W : sh[W-1:0];
      end else begin
         res = (sh > MIN_P) ? MIN_W : (~sh[W-1:0] + 1'b1);
      end
      return res;
   endfunction

   // Saturate a sum one bit wider than a coordinate.
   function automatic logic [W-1:0] clamp(input logic [W:0] v);
      logic [W-1:0] res;
      if (v[W] != v[W-1]) begin
         res = v[W] ? MIN_W : POS_W;
      end else begin
         res = v[W-1:0];
      end
      return res;
   endfunction

   function automatic logic [W-1:0] mag(input logic [W-1:0] v);
      return v[W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic outside(input logic signed [W-1:0] v,
                                    input logic signed [W-1:0] e0,
                                    input logic signed [W-1:0] e1);
      return (v < e0 && v < e1) || (v > e0 && v > e1);
   endfunction

   // The pipeline never stalls.
   assign busy = 1'b0;

   // ---------------- Stage 1: capture the beat ----------------
   logic                v1_ff;
   logic [NC-1:0][W-1:0] crd1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
      crd1_ff[sit_pkg::P1X] <= req_a_start_x;
      crd1_ff[sit_pkg::P1Y] <= req_a_start_y;
      crd1_ff[sit_pkg::Q1X] <= req_a_end_x;
      crd1_ff[sit_pkg::Q1Y] <= req_a_end_y;
      crd1_ff[sit_pkg::P2X] <= req_b_start_x;
      crd1_ff[sit_pkg::P2Y] <= req_b_start_y;
      crd1_ff[sit_pkg::Q2X] <= req_b_end_x;
      crd1_ff[sit_pkg::Q2Y] <= req_b_end_y;
   end

   // ---------------- Stage 2: differences and early rejects ----------------
   logic signed [W:0] dx1_in, dy1_in, dx2_in, dy2_in;
   logic              kill2_in;
   logic              v2_ff, kill2_ff, z1_2_ff, z2_2_ff;
   logic [W:0]        dx1_ff, dy1_ff, dx2_ff, dy2_ff;
   logic [NC-1:0][W-1:0] crd2_ff;

   assign dx1_in = (W+1)'($signed(crd1_ff[sit_pkg::Q1X])) - (W+1)'($signed(crd1_ff[sit_pkg::P1X]));
   assign dy1_in = (W+1)'($signed(crd1_ff[sit_pkg::Q1Y])) - (W+1)'($signed(crd1_ff[sit_pkg::P1Y]));
   assign dx2_in = (W+1)'($signed(crd1_ff[sit_pkg::Q2X])) - (W+1)'($signed(crd1_ff[sit_pkg::P2X]));
   assign dy2_in = (W+1)'($signed(crd1_ff[sit_pkg::Q2Y])) - (W+1)'($signed(crd1_ff[sit_pkg::P2Y]));

   // Shared end point, degenerate segment or two vertical segments.
   assign kill2_in = (crd1_ff[sit_pkg::Q1X] == crd1_ff[sit_pkg::Q2X] &&
                      crd1_ff[sit_pkg::Q1Y] == crd1_ff[sit_pkg::Q2Y]) ||
                     (dx1_in == '0 && dy1_in == '0) ||
                     (dx2_in == '0 && dy2_in == '0) ||
                     (dx1_in == '0 && dx2_in == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      kill2_ff <= kill2_in;
      z1_2_ff  <= (dx1_in == '0);
      z2_2_ff  <= (dx2_in == '0);
      dx1_ff   <= dx1_in;
      dy1_ff   <= dy1_in;
      dx2_ff   <= dx2_in;
      dy2_ff   <= dy2_in;
      crd2_ff  <= crd1_ff;
   end

   // ---------------- Slope dividers ----------------
   logic          va_out, vb_out;
   logic [W-1:0]  s1_q, s2_q;
   logic [TA-1:0] tag_a;
   logic [0:0]    tag_b;

   sit_div #(.NW(W+1), .FB(F), .OW(W), .TW(TA)) u_div_s1 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_num    (dy1_ff),
      .in_den    (dx1_ff),
      .in_tag    ({crd2_ff, z1_2_ff, z2_2_ff}),
      .out_valid (va_out),
      .out_quo   (s1_q),
      .out_tag   (tag_a)
   );

   sit_div #(.NW(W+1), .FB(F), .OW(W), .TW(1)) u_div_s2 (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2_ff),
      .in_num    (dy2_ff),
      .in_den    (dx2_ff),
      .in_tag    (kill2_ff),
      .out_valid (vb_out),
      .out_quo   (s2_q),
      .out_tag   (tag_b)
   );

   // ---------------- Stage 3: end x times slope ----------------
   logic [NC-1:0][W-1:0] crd3_in;
   logic                 v3_ff, kill3_ff, z1_3_ff, z2_3_ff, n1_3_ff, n2_3_ff;
   logic [2*W-1:0]       p1_3_ff, p2_3_ff;
   logic [W-1:0]         s1_3_ff, s2_3_ff;
   logic [NC-1:0][W-1:0] crd3_ff;

   assign crd3_in = tag_a[TA-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= va_out & vb_out;
      end
      kill3_ff <= tag_b[0];
      z1_3_ff  <= tag_a[1];
      z2_3_ff  <= tag_a[0];
      p1_3_ff  <= (2*W)'(mag(crd3_in[sit_pkg::Q1X])) * (2*W)'(mag(s1_q));
      p2_3_ff  <= (2*W)'(mag(crd3_in[sit_pkg::Q2X])) * (2*W)'(mag(s2_q));
      n1_3_ff  <= crd3_in[sit_pkg::Q1X][W-1] ^ s1_q[W-1];
      n2_3_ff  <= crd3_in[sit_pkg::Q2X][W-1] ^ s2_q[W-1];
      s1_3_ff  <= s1_q;
      s2_3_ff  <= s2_q;
      crd3_ff  <= crd3_in;
   end

   // ---------------- Stage 4: scale and saturate the products ----------------
   logic                 v4_ff, kill4_ff, z1_4_ff, z2_4_ff;
   logic [W-1:0]         m1_4_ff, m2_4_ff, s1_4_ff, s2_4_ff;
   logic [NC-1:0][W-1:0] crd4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
      kill4_ff <= kill3_ff;
      z1_4_ff  <= z1_3_ff;
      z2_4_ff  <= z2_3_ff;
      m1_4_ff  <= sat_mul(p1_3_ff, n1_3_ff);
      m2_4_ff  <= sat_mul(p2_3_ff, n2_3_ff);
      s1_4_ff  <= s1_3_ff;
      s2_4_ff  <= s2_3_ff;
      crd4_ff  <= crd3_ff;
   end

   // ---------------- Stage 5: intercepts ----------------
   logic                 v5_ff, kill5_ff, z1_5_ff, z2_5_ff;
   logic [W-1:0]         i1_5_ff, i2_5_ff, s1_5_ff, s2_5_ff;
   logic [NC-1:0][W-1:0] crd5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else begin
         v5_ff <= v4_ff;
      end
      kill5_ff <= kill4_ff;
      z1_5_ff  <= z1_4_ff;
      z2_5_ff  <= z2_4_ff;
      i1_5_ff  <= clamp((W+1)'($signed(crd4_ff[sit_pkg::Q1Y])) - (W+1)'($signed(m1_4_ff)));
      i2_5_ff  <= clamp((W+1)'($signed(crd4_ff[sit_pkg::Q2Y])) - (W+1)'($signed(m2_4_ff)));
      s1_5_ff  <= s1_4_ff;
      s2_5_ff  <= s2_4_ff;
      crd5_ff  <= crd4_ff;
   end

   // ---------------- Crossing x divider ----------------
   logic [W:0]    num_in, den_in;
   logic          kill6_in;
   logic          vc_out;
   logic [W-1:0]  xq;
   logic [TC-1:0] tag_c;

   assign num_in = (W+1)'($signed(i2_5_ff)) - (W+1)'($signed(i1_5_ff));
   assign den_in = (W+1)'($signed(s1_5_ff)) - (W+1)'($signed(s2_5_ff));

   // Equal slopes of two sloped segments mean parallel lines.
   assign kill6_in = kill5_ff || (!z1_5_ff && !z2_5_ff && s1_5_ff == s2_5_ff);

   sit_div #(.NW(W+1), .FB(F), .OW(W), .TW(TC)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v5_ff),
      .in_num    (num_in),
      .in_den    (den_in),
      .in_tag    ({crd5_ff, s1_5_ff, s2_5_ff, i1_5_ff, i2_5_ff,
                   z1_5_ff, z2_5_ff, kill6_in}),
      .out_valid (vc_out),
      .out_quo   (xq),
      .out_tag   (tag_c)
   );

   // ---------------- Stage 7: pick x and the line, multiply ----------------
   logic [NC-1:0][W-1:0] crd7_in;
   logic [W-1:0]         s1_7_in, s2_7_in, i1_7_in, i2_7_in, x7_in, sl7_in;
   logic                 z1_7_in, z2_7_in;
   logic                 v7_ff, kill7_ff, n7_ff;
   logic [2*W-1:0]       p7_ff;
   logic [W-1:0]         x7_ff, ic7_ff;
   logic [NC-1:0][W-1:0] crd7_ff;

   assign crd7_in = tag_c[TC-1 -: NC*W];
   assign s1_7_in = tag_c[4*W+2 -: W];
   assign s2_7_in = tag_c[3*W+2 -: W];
   assign i1_7_in = tag_c[2*W+2 -: W];
   assign i2_7_in = tag_c[W+2 -: W];
   assign z1_7_in = tag_c[2];
   assign z2_7_in = tag_c[1];

   // A vertical segment fixes x; y then comes from the other line.
   assign x7_in  = z1_7_in ? crd7_in[sit_pkg::P1X] :
                   (z2_7_in ? crd7_in[sit_pkg::P2X] : xq);
   assign sl7_in = z1_7_in ? s2_7_in : s1_7_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff <= 1'b0;
      end else begin
         v7_ff <= vc_out;
      end
      kill7_ff <= tag_c[0];
      p7_ff    <= (2*W)'(mag(sl7_in)) * (2*W)'(mag(x7_in));
      n7_ff    <= sl7_in[W-1] ^ x7_in[W-1];
      x7_ff    <= x7_in;
      ic7_ff   <= z1_7_in ? i2_7_in : i1_7_in;
      crd7_ff  <= crd7_in;
   end

   // ---------------- Stage 8: scale the product ----------------
   logic                 v8_ff, kill8_ff;
   logic [W-1:0]         m8_ff, x8_ff, ic8_ff;
   logic [NC-1:0][W-1:0] crd8_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v8_ff <= 1'b0;
      end else begin
         v8_ff <= v7_ff;
      end
      kill8_ff <= kill7_ff;
      m8_ff    <= sat_mul(p7_ff, n7_ff);
      x8_ff    <= x7_ff;
      ic8_ff   <= ic7_ff;
      crd8_ff  <= crd7_ff;
   end

   // ---------------- Stage 9: crossing y ----------------
   logic                 v9_ff, kill9_ff;
   logic [W-1:0]         x9_ff, y9_ff;
   logic [NC-1:0][W-1:0] crd9_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v9_ff <= 1'b0;
      end else begin
         v9_ff <= v8_ff;
      end
      kill9_ff <= kill8_ff;
      x9_ff    <= x8_ff;
      y9_ff    <= clamp((W+1)'($signed(m8_ff)) + (W+1)'($signed(ic8_ff)));
      crd9_ff  <= crd8_ff;
   end

   // ---------------- Stage 10: range checks and result ----------------
   logic hit_in;
   logic v10_ff, hit10_ff;

   assign hit_in = !kill9_ff &&
      !outside(x9_ff, crd9_ff[sit_pkg::P1X], crd9_ff[sit_pkg::Q1X]) &&
      !outside(y9_ff, crd9_ff[sit_pkg::P1Y], crd9_ff[sit_pkg::Q1Y]) &&
      !outside(x9_ff, crd9_ff[sit_pkg::P2X], crd9_ff[sit_pkg::Q2X]) &&
      !outside(y9_ff, crd9_ff[sit_pkg::P2Y], crd9_ff[sit_pkg::Q2Y]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v10_ff <= 1'b0;
      end else begin
         v10_ff <= v9_ff;
      end
      hit10_ff <= hit_in;
   end

   assign rsp_valid   = v10_ff;
   assign rsp_crosses = hit10_ff;

endmodule

`default_nettype wire

FILE: bench/sit_checker.sv
// -----------------------------------------------------------------------------
// Segment intersection checker
// Watches the request and response beats, predicts the crossing answer for
// each accepted segment pair and compares it with the response that comes out.
// -----------------------------------------------------------------------------
`default_nettype none

module sit_checker #(
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic                         busy,
   input  wire logic signed [COORD_BITS-1:0] req_a_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_a_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_a_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_a_end_y,
   input  wire logic signed [COORD_BITS-1:0] req_b_start_x,
   input  wire logic signed [COORD_BITS-1:0] req_b_start_y,
   input  wire logic signed [COORD_BITS-1:0] req_b_end_x,
   input  wire logic signed [COORD_BITS-1:0] req_b_end_y,
   input  wire logic                         rsp_valid,
   input  wire logic                         rsp_crosses,
   output int                                fail_count,
   output int                                pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;

   bit crossing_answers[$];

   function automatic longint clamp_coord(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   // Apply a sign to an unsigned magnitude and saturate to the coordinate range.
   function automatic longint sat_signed(bit neg, longint unsigned m);
      if (!neg) return (m > longint'(COORD_MAX)) ? COORD_MAX : longint'(m);
      return (m > longint'(COORD_MAX) + 1) ? COORD_MIN : -longint'(m);
   endfunction

   function automatic longint unsigned abs_val(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // Fixed-point product, truncated toward zero.
   function automatic longint fx_mul(longint a, longint b);
      longint unsigned p;
      p = (abs_val(a) * abs_val(b)) >> FRAC_BITS;
      return sat_signed((a < 0) != (b < 0), p);
   endfunction

   // Fixed-point quotient, truncated toward zero; a zero divisor gives zero.
   function automatic longint fx_div(longint n, longint d);
      longint unsigned q;
      if (d == 0) return 0;
      q = (abs_val(n) << FRAC_BITS) / abs_val(d);
      return sat_signed((n < 0) != (d < 0), q);
   endfunction

   function automatic bit out_of_span(longint v, longint e0, longint e1);
      return (v < e0 && v < e1) || (v > e0 && v > e1);
   endfunction

   function automatic bit segments_cross(longint p1x, longint p1y, longint q1x,
                                         longint q1y, longint p2x, longint p2y,
                                         longint q2x, longint q2y);
      longint dx1, dy1, dx2, dy2, s1, i1, s2, i2, x, y;
      dx1 = q1x - p1x;
      dy1 = q1y - p1y;
      dx2 = q2x - p2x;
      dy2 = q2y - p2y;
      s1 = 0;
      i1 = 0;
      s2 = 0;
      i2 = 0;
      // Shared end point, degenerate segments and two verticals never cross.
      if (q1x == q2x && q1y == q2y) return 1'b0;
      if (dx1 == 0 && dy1 == 0) return 1'b0;
      if (dx2 == 0 && dy2 == 0) return 1'b0;
      if (dx1 == 0 && dx2 == 0) return 1'b0;
      if (dx1 != 0) begin
         s1 = fx_div(dy1, dx1);
         i1 = clamp_coord(q1y - fx_mul(q1x, s1));
      end
      if (dx2 != 0) begin
         s2 = fx_div(dy2, dx2);
         i2 = clamp_coord(q2y - fx_mul(q2x, s2));
      end
      if (dx1 == 0) begin
         x = p1x;
         y = clamp_coord(fx_mul(s2, x) + i2);
      end else if (dx2 == 0) begin
         x = p2x;
         y = clamp_coord(fx_mul(s1, x) + i1);
      end else begin
         if (s1 == s2) return 1'b0;
         x = fx_div(i2 - i1, s1 - s2);
         y = clamp_coord(fx_mul(s1, x) + i1);
      end
      return !out_of_span(x, p1x, q1x) && !out_of_span(y, p1y, q1y) &&
             !out_of_span(x, p2x, q2x) && !out_of_span(y, p2y, q2y);
   endfunction

   assign pending = crossing_answers.size();

   // Predict on each request beat and compare on each response beat.
   always @(posedge clock) begin
      bit want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (start && !busy)
            crossing_answers.push_back(segments_cross(
               req_a_start_x, req_a_start_y, req_a_end_x, req_a_end_y,
               req_b_start_x, req_b_start_y, req_b_end_x, req_b_end_y));
         if (rsp_valid) begin
            if (crossing_answers.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: response beat with no request waiting", $realtime);
               fail_count <= fail_count + 1;
            end else begin
               want = crossing_answers.pop_front();
               if (rsp_crosses !== want) begin
                  if (fail_count < 10)
                     $display("%0t: crosses expected %0b, got %0b", $realtime, want,
                              rsp_crosses);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: bench/tb_segment_intersection_test_top.sv
// -----------------------------------------------------------------------------
// Segment intersection testbench
// Drives directed corner cases and then random segment pairs, mostly small
// segments that often cross, with random gaps; the checker judges each answer.
// -----------------------------------------------------------------------------
`default_nettype none

module tb_segment_intersection_test_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS = 32;
   localparam int FRAC_BITS  = 16;
   localparam int LATENCY    = 2 * (COORD_BITS + FRAC_BITS + 3) + 9;

   typedef logic signed [COORD_BITS-1:0] coord_t;

   localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam coord_t ONE  = coord_t'(1) <<< FRAC_BITS;

   logic   clock, reset, start, busy, rsp_valid, rsp_crosses;
   coord_t a_sx, a_sy, a_ex, a_ey, b_sx, b_sy, b_ex, b_ey;
   int     fail_count, pending;
   bit     no_gaps;

   segment_intersection_test_top #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_start_x(a_sx), .req_a_start_y(a_sy), .req_a_end_x(a_ex), .req_a_end_y(a_ey),
      .req_b_start_x(b_sx), .req_b_start_y(b_sy), .req_b_end_x(b_ex), .req_b_end_y(b_ey),
      .rsp_valid(rsp_valid), .rsp_crosses(rsp_crosses)
   );

   sit_checker #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_a_start_x(a_sx), .req_a_start_y(a_sy), .req_a_end_x(a_ex), .req_a_end_y(a_ey),
      .req_b_start_x(b_sx), .req_b_start_y(b_sy), .req_b_end_x(b_ex), .req_b_end_y(b_ey),
      .rsp_valid(rsp_valid), .rsp_crosses(rsp_crosses),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2ms;
      $display("FAILURE");
      $finish;
   end

   // Present one segment pair after a random gap and hold it until accepted.
   task automatic send_pair(coord_t p1x, coord_t p1y, coord_t q1x, coord_t q1y,
                            coord_t p2x, coord_t p2y, coord_t q2x, coord_t q2y);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      a_sx <= p1x; a_sy <= p1y; a_ex <= q1x; a_ey <= q1y;
      b_sx <= p2x; b_sy <= p2y; b_ex <= q2x; b_ey <= q2y;
      do @(posedge clock); while (busy);
   endtask

   // Coordinates of the random part: mostly a small window so that many pairs
   // cross, sometimes the full range.
   function automatic coord_t rand_coord(bit wide);
      if (wide) return coord_t'($urandom);
      return coord_t'(($urandom_range(0, 40) - 20) * 65536 + $urandom_range(0, 65535));
   endfunction

   initial begin
      coord_t c[8];
      int     kind;
      start = 1'b0;
      no_gaps = 1'b0;
      {a_sx, a_sy, a_ex, a_ey, b_sx, b_sy, b_ex, b_ey} = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corner cases.
      send_pair(0, 0, 4*ONE, 4*ONE, 0, 4*ONE, 4*ONE, 0);          // plain cross
      send_pair(0, 0, 4*ONE, 4*ONE, 5*ONE, 0, 4*ONE, 4*ONE);      // same end points
      send_pair(ONE, ONE, ONE, ONE, 0, 4*ONE, 4*ONE, 0);          // first degenerate
      send_pair(0, 0, 4*ONE, 4*ONE, 3*ONE, 2*ONE, 3*ONE, 2*ONE);  // second degenerate
      send_pair(ONE, 0, ONE, 4*ONE, 2*ONE, 0, 2*ONE, 4*ONE);      // both vertical
      send_pair(2*ONE, 0, 2*ONE, 4*ONE, 0, 0, 4*ONE, 4*ONE);      // first vertical
      send_pair(0, 0, 4*ONE, 4*ONE, 2*ONE, 0, 2*ONE, 4*ONE);      // second vertical
      send_pair(9*ONE, 0, 9*ONE, 4*ONE, 0, 0, 4*ONE, 4*ONE);      // vertical, misses
      send_pair(0, 0, 4*ONE, 4*ONE, 0, ONE, 4*ONE, 5*ONE);        // parallel
      send_pair(0, 0, 4*ONE, 0, 2*ONE, -ONE, 2*ONE, ONE);         // horizontal and vertical
      send_pair(0, 0, ONE, ONE, 5*ONE, 0, 6*ONE, -ONE);           // lines cross outside
      send_pair(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN);  // full range diagonals
      send_pair(CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX);
      send_pair(CMIN, 0, CMIN + 1, CMAX, 0, CMIN, CMAX, CMIN + 1); // saturated slopes
      send_pair(0, CMIN, 1, CMAX, CMAX, 0, CMIN, 1);
      send_pair(-1, -1, 1, 1, -1, 1, 1, -1);                      // tiny cross
      send_pair(CMAX, 0, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX);     // verticals at extremes
      send_pair(0, 0, CMAX, 1, 0, 1, CMAX, 0);                    // shallow slopes
      send_pair('1, '1, CMAX, CMIN, CMIN, CMAX, '1, 0);
      send_pair(3*ONE, 3*ONE, -3*ONE, -3*ONE, -3*ONE, 3*ONE, 3*ONE, -3*ONE);

      // Let everything drain before the random part.
      start <= 1'b0;
      wait (pending == 0);
      @(posedge clock);

      // Random part, with stretches of back-to-back beats.
      for (int n = 0; n < 760; n++) begin
         if (n % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
         kind = $urandom_range(0, 9);
         foreach (c[k]) c[k] = rand_coord(kind < 2);
         case (kind)
            8: begin
               // Vertical or horizontal segments on shared coordinates.
               if ($urandom_range(0, 1)) c[2] = c[0]; else c[3] = c[1];
               if ($urandom_range(0, 1)) c[6] = c[4]; else c[7] = c[5];
            end
            9: begin
               case ($urandom_range(0, 3))
                  0: begin c[6] = c[2]; c[7] = c[3]; end
                  1: begin c[2] = c[0]; c[3] = c[1]; end
                  2: begin c[2] = c[0]; c[6] = c[4]; end
                  default: begin
                     // Second segment is the first shifted sideways.
                     c[4] = c[0] + ONE; c[6] = c[2] + ONE;
                     c[5] = c[1];       c[7] = c[3];
                  end
               endcase
            end
            default: ;
         endcase
         send_pair(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]);
      end
      start <= 1'b0;

      wait (pending == 0);
      repeat (LATENCY + 20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: segment_intersection_test_top.f
hdl/sit_pkg.sv
hdl/sit_div.sv
hdl/segment_intersection_test_top.sv
bench/sit_checker.sv
bench/tb_segment_intersection_test_top.sv
